/* src/b2da_pkg.sv */
// ----------------------------------------------------------------------------
// b2da_pkg
// shared types and constants for the binary to decimal ascii converter
// ----------------------------------------------------------------------------
`default_nettype none
package b2da_pkg;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2d;
endpackage
`default_nettype wire

/* src/b2da_dabble.sv */
// ----------------------------------------------------------------------------
// b2da_dabble
// pipelined shift-and-add-3, STEP_BITS input bits per stage, with stall
// ----------------------------------------------------------------------------
`default_nettype none
module b2da_dabble
    import b2da_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int BCD_DEPTH = 10,
    parameter int STEP_BITS = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [WORD_BITS-1:0]   i_mag,
    input  wire logic                   i_neg,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [4*BCD_DEPTH-1:0]      o_bcd,
    output logic                        o_neg
);
    localparam int NSTAGE = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PADW   = NSTAGE * STEP_BITS;

    logic [NSTAGE:0]                 r_vld;
    logic [PADW-1:0]                 r_bin [NSTAGE+1];
    logic [4*BCD_DEPTH-1:0]          r_bcd [NSTAGE+1];
    logic [NSTAGE:0]                 r_neg;
    logic [NSTAGE:0]                 w_adv;
    logic [PADW-1:0]                 n_bin [NSTAGE+1];
    logic [4*BCD_DEPTH-1:0]          n_bcd [NSTAGE+1];

    // stage k advances when empty or its successor takes
    always_comb begin
        w_adv[NSTAGE] = !r_vld[NSTAGE] || i_ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NSTAGE];
    assign o_bcd   = r_bcd[NSTAGE];
    assign o_neg   = r_neg[NSTAGE];

    always_comb begin
        // padding goes on top so it shifts in as leading zeros
        n_bin[0] = PADW'(i_mag);
        n_bcd[0] = '0;
        for (int k = 1; k <= NSTAGE; k++) begin
            logic [4*BCD_DEPTH-1:0] b;
            logic [PADW-1:0]        s;
            b = r_bcd[k-1];
            s = r_bin[k-1];
            for (int j = 0; j < STEP_BITS; j++) begin
                for (int d = 0; d < BCD_DEPTH; d++) begin
                    if (b[4*d +: 4] >= 4'd5) begin
                        b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                    end
                end
                b = {b[4*BCD_DEPTH-2:0], s[PADW-1]};
                s = {s[PADW-2:0], 1'b0};
            end
            n_bin[k] = s;
            n_bcd[k] = b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld[0] <= w_adv[0] ? i_valid : r_vld[0];
            for (int k = 1; k <= NSTAGE; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_bin[0] <= n_bin[0];
            r_bcd[0] <= n_bcd[0];
            r_neg[0] <= i_neg;
        end
        for (int k = 1; k <= NSTAGE; k++) begin
            if (w_adv[k]) begin
                r_bin[k] <= n_bin[k];
                r_bcd[k] <= n_bcd[k];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end
endmodule
`default_nettype wire

/* src/b2da_emit.sv */
// ----------------------------------------------------------------------------
// b2da_emit
// serializes one bcd word into ascii characters, sign first
// ----------------------------------------------------------------------------
`default_nettype none
module b2da_emit
    import b2da_pkg::*;
#(
    parameter int BCD_DEPTH = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [4*BCD_DEPTH-1:0] i_bcd,
    input  wire logic                   i_neg,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [7:0]                  o_char,
    output logic                        o_last
);
    localparam int PW = $clog2(BCD_DEPTH + 1);

    logic                   r_busy;
    logic [4*BCD_DEPTH-1:0] r_bcd;
    logic                   r_sign;
    logic [PW-1:0]          r_pos;
    logic                   r_ov;
    logic [7:0]             r_char;
    logic                   r_last;
    logic [PW-1:0]          w_top;
    logic                   w_take;
    logic [3:0]             w_dig;

    always_comb begin
        w_top = '0;
        for (int d = 1; d < BCD_DEPTH; d++) begin
            if (i_bcd[4*d +: 4] != 4'd0) begin
                w_top = PW'(d);
            end
        end
    end

    assign w_take  = !r_ov || i_ready;
    assign o_ready = !r_busy;
    assign o_valid = r_ov;
    assign o_char  = r_char;
    assign o_last  = r_last;
    assign w_dig   = r_bcd[4*r_pos +: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (w_take) begin
                r_ov <= r_busy;
            end
            if (!r_busy) begin
                if (i_valid) begin
                    r_busy <= 1'b1;
                    r_bcd  <= i_bcd;
                    r_sign <= i_neg;
                    r_pos  <= w_top;
                end
            end else if (w_take) begin
                if (r_sign) begin
                    r_char <= ASCII_MINUS;
                    r_last <= 1'b0;
                    r_sign <= 1'b0;
                end else begin
                    r_char <= ASCII_ZERO + {4'd0, w_dig};
                    r_last <= (r_pos == '0);
                    if (r_pos == '0) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_pos <= r_pos - 1'b1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

/* src/binary_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// binary word to decimal ascii text for a character display
//
// slave side s_axis takes one 32-bit word per request; master side m_axis
// gives its decimal text one character per request, most significant first,
// with tlast on the final character. leading zeros dropped, zero gives "0".
// config channel writes signed_mode; with it set, negative words get '-'.
// the conversion pipeline has an input register and ceil(WORD_BITS/4)
// stages of four shift-add-3 steps each (9 registers at 32 bits);
// a new word can enter every cycle while the pipeline is not backed up.
// the character serializer loads a word, then sends 1 to 11 characters,
// one per cycle while the receiver is ready; it takes no new word until
// it has produced the last character of the current one, and so it limits
// the sustained word rate.
// reset empties all stages and clears signed_mode.
// a stalled receiver holds the current character; the pipeline backs up
// without loss and then stops taking words.
// ----------------------------------------------------------------------------
`default_nettype none
module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,     // signed_mode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // value_word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // text_char
    output logic             m_axis_tlast    // last_char
);
    localparam int BCD_DEPTH = (WORD_BITS * 30103 / 100000) + 1;

    logic                   r_signed_mode;
    logic [WORD_BITS-1:0]   w_raw;
    logic                   w_neg;
    logic [WORD_BITS-1:0]   w_mag;
    logic                   w_dv;
    logic                   w_dr;
    logic [4*BCD_DEPTH-1:0] w_bcd;
    logic                   w_dneg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_signed_mode <= i_cfg_data;
        end
    end

    assign w_raw = WORD_BITS'(s_axis_tdata);
    assign w_neg = r_signed_mode && w_raw[WORD_BITS-1];
    assign w_mag = w_neg ? (~w_raw + 1'b1) : w_raw;

    b2da_dabble #(
        .WORD_BITS (WORD_BITS),
        .BCD_DEPTH (BCD_DEPTH),
        .STEP_BITS (4)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mag   (w_mag),
        .i_neg   (w_neg),
        .o_valid (w_dv),
        .i_ready (w_dr),
        .o_bcd   (w_bcd),
        .o_neg   (w_dneg)
    );

    b2da_emit #(
        .BCD_DEPTH (BCD_DEPTH)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dv),
        .o_ready (w_dr),
        .i_bcd   (w_bcd),
        .i_neg   (w_dneg),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );
endmodule
`default_nettype wire
